@@ rtl/pcf_pkg.sv @@
package pcf_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int COEF_BITS          = 24;
    localparam int LIMIT_BITS         = 16;
    localparam int CFG_INDEX_BITS     = 3;
    localparam int CFG_DATA_BITS      = 24;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PI_COEF_NOW    = 3'd0,
        REG_PI_COEF_PREV   = 3'd1,
        REG_PRE_COEF_NOW   = 3'd2,
        REG_PRE_COEF_PREV  = 3'd3,
        REG_PRE_FB_COEF    = 3'd4,
        REG_OUT_LOW_LIMIT  = 3'd5,
        REG_OUT_HIGH_LIMIT = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        LIM_NONE = 2'd0,
        LIM_HIGH = 2'd1,
        LIM_LOW  = 2'd2
    } limit_flag_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0]  pi_coef_now;
        logic signed [COEF_BITS-1:0]  pi_coef_prev;
        logic signed [COEF_BITS-1:0]  pre_coef_now;
        logic signed [COEF_BITS-1:0]  pre_coef_prev;
        logic signed [COEF_BITS-1:0]  pre_fb_coef;
        logic signed [LIMIT_BITS-1:0] out_low_limit;
        logic signed [LIMIT_BITS-1:0] out_high_limit;
    } pcf_coefs_t;

endpackage

@@ rtl/pcf_cfg.sv @@
module pcf_cfg
    import pcf_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output pcf_coefs_t                coefs
);

    localparam logic signed [COEF_BITS-1:0] UNITY = COEF_BITS'(1) << COEF_FRAC_BITS;

    pcf_coefs_t coefs_reg;
    pcf_coefs_t coefs_next;

    assign cfg_ready = 1'b1;
    assign coefs     = coefs_reg;

    always_comb begin
        coefs_next = coefs_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_PI_COEF_NOW:    coefs_next.pi_coef_now    = cfg_data[COEF_BITS-1:0];
                REG_PI_COEF_PREV:   coefs_next.pi_coef_prev   = cfg_data[COEF_BITS-1:0];
                REG_PRE_COEF_NOW:   coefs_next.pre_coef_now   = cfg_data[COEF_BITS-1:0];
                REG_PRE_COEF_PREV:  coefs_next.pre_coef_prev  = cfg_data[COEF_BITS-1:0];
                REG_PRE_FB_COEF:    coefs_next.pre_fb_coef    = cfg_data[COEF_BITS-1:0];
                REG_OUT_LOW_LIMIT:  coefs_next.out_low_limit  = cfg_data[LIMIT_BITS-1:0];
                REG_OUT_HIGH_LIMIT: coefs_next.out_high_limit = cfg_data[LIMIT_BITS-1:0];
                default:            coefs_next = coefs_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg.pi_coef_now    <= UNITY;
            coefs_reg.pi_coef_prev   <= '0;
            coefs_reg.pre_coef_now   <= UNITY;
            coefs_reg.pre_coef_prev  <= '0;
            coefs_reg.pre_fb_coef    <= '0;
            coefs_reg.out_low_limit  <= {1'b1, {(LIMIT_BITS-1){1'b0}}};
            coefs_reg.out_high_limit <= {1'b0, {(LIMIT_BITS-1){1'b1}}};
        end else begin
            coefs_reg <= coefs_next;
        end
    end

endmodule

@@ rtl/pcf_mul.sv @@
module pcf_mul
    import pcf_pkg::*;
#(
    parameter int A_BITS = COEF_BITS,
    parameter int B_BITS = 33
) (
    input  logic                             aclk,
    input  logic signed [A_BITS-1:0]         op_a,
    input  logic signed [B_BITS-1:0]         op_b,
    output logic signed [A_BITS+B_BITS-1:0]  prod
);

    logic signed [A_BITS+B_BITS-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= (A_BITS+B_BITS)'(op_a) * (A_BITS+B_BITS)'(op_b);
    end

endmodule

@@ rtl/pcf_core.sv @@
module pcf_core
    import pcf_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pcf_coefs_t                    coefs,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] setpoint,
    input  logic signed [SAMPLE_BITS-1:0] measured,
    input  logic                          out_free,
    output logic                          res_valid,
    output logic [SAMPLE_BITS-1:0]        res_drive,
    output limit_flag_t                   res_flag
);

    localparam int CF  = COEF_FRAC_BITS;
    localparam int QB  = SAMPLE_BITS + CF;
    localparam int EW  = QB + 1;
    localparam int UW  = ((SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS) + CF;
    localparam int MB  = (EW > UW) ? EW : UW;
    localparam int PW  = COEF_BITS + MB;
    localparam int AW  = PW + 2;
    localparam int RW  = AW - CF;

    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (CF - 1);
    localparam logic signed [RW-1:0] QMAX = (RW'(1) <<< (QB - 1)) - RW'(1);
    localparam logic signed [RW-1:0] QMIN = ~QMAX;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_PRE_SUM,
        ST_PRE_RND,
        ST_ERR,
        ST_PI_A,
        ST_PI_B,
        ST_PI_SUM,
        ST_CLAMP
    } state_t;

    state_t                  state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic signed [SAMPLE_BITS-1:0] fb_reg, fb_next;
    logic signed [AW-1:0]    acc_reg, acc_next;
    logic signed [SAMPLE_BITS-1:0] pre_in_reg, pre_in_next;
    logic signed [QB-1:0]    pre_out_reg, pre_out_next;
    logic signed [EW-1:0]    err_reg, err_next;
    logic signed [EW-1:0]    err_last_reg, err_last_next;
    logic signed [UW-1:0]    ctl_out_reg, ctl_out_next;

    logic signed [COEF_BITS-1:0] mul_a;
    logic signed [MB-1:0]        mul_b;
    logic signed [PW-1:0]        prod;
    logic signed [AW-1:0]        prod_ext;
    logic signed [AW-1:0]        rnd_sum;
    logic signed [RW-1:0]        rnd_val;
    logic signed [RW-1:0]        hi_u, lo_u, u_cl;
    logic signed [QB-1:0]        pre_sat;
    limit_flag_t                 flag;

    pcf_mul #(
        .A_BITS (COEF_BITS),
        .B_BITS (MB)
    ) u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // operand select for the shared multiplier
    always_comb begin
        case (state_reg)
            ST_MUL_A: begin
                mul_a = coefs.pre_coef_now;
                mul_b = MB'(x_reg);
            end
            ST_MUL_B: begin
                mul_a = coefs.pre_coef_prev;
                mul_b = MB'(pre_in_reg);
            end
            ST_MUL_C: begin
                mul_a = coefs.pre_fb_coef;
                mul_b = MB'(pre_out_reg);
            end
            ST_PI_A: begin
                mul_a = coefs.pi_coef_now;
                mul_b = MB'(err_reg);
            end
            ST_PI_B: begin
                mul_a = coefs.pi_coef_prev;
                mul_b = MB'(err_last_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_ext = AW'(prod);

    // round to nearest, ties up; shared by prefilter and PI result
    assign rnd_sum = acc_reg + HALF;
    assign rnd_val = RW'(rnd_sum >>> CF);

    assign pre_sat = (rnd_val > QMAX) ? QB'(QMAX) :
                     (rnd_val < QMIN) ? QB'(QMIN) : QB'(rnd_val);

    assign hi_u = RW'(coefs.out_high_limit) <<< CF;
    assign lo_u = RW'(coefs.out_low_limit) <<< CF;

    always_comb begin
        if (rnd_val > hi_u) begin
            u_cl = hi_u;
            flag = LIM_HIGH;
        end else if (rnd_val < lo_u) begin
            u_cl = lo_u;
            flag = LIM_LOW;
        end else begin
            u_cl = rnd_val;
            flag = LIM_NONE;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_CLAMP) && out_free;
    assign res_drive = SAMPLE_BITS'(u_cl >>> CF);
    assign res_flag  = flag;

    always_comb begin
        state_next    = state_reg;
        x_next        = x_reg;
        fb_next       = fb_reg;
        acc_next      = acc_reg;
        pre_in_next   = pre_in_reg;
        pre_out_next  = pre_out_reg;
        err_next      = err_reg;
        err_last_next = err_last_reg;
        ctl_out_next  = ctl_out_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    x_next     = setpoint;
                    fb_next    = measured;
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A: state_next = ST_MUL_B;
            ST_MUL_B: begin
                acc_next   = prod_ext <<< CF;
                state_next = ST_MUL_C;
            end
            ST_MUL_C: begin
                acc_next   = acc_reg + (prod_ext <<< CF);
                state_next = ST_PRE_SUM;
            end
            ST_PRE_SUM: begin
                acc_next   = acc_reg - prod_ext;
                state_next = ST_PRE_RND;
            end
            ST_PRE_RND: begin
                // old prefilter output was consumed in ST_MUL_C
                pre_out_next = pre_sat;
                state_next   = ST_ERR;
            end
            ST_ERR: begin
                err_next   = EW'(pre_out_reg) - (EW'(fb_reg) <<< CF);
                state_next = ST_PI_A;
            end
            ST_PI_A: begin
                acc_next   = AW'(ctl_out_reg) <<< CF;
                state_next = ST_PI_B;
            end
            ST_PI_B: begin
                acc_next   = acc_reg + prod_ext;
                state_next = ST_PI_SUM;
            end
            ST_PI_SUM: begin
                acc_next   = acc_reg + prod_ext;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                // hold until the output register can take the beat
                if (out_free) begin
                    pre_in_next   = x_reg;
                    err_last_next = err_reg;
                    ctl_out_next  = UW'(u_cl);
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pre_in_reg   <= '0;
            pre_out_reg  <= '0;
            err_last_reg <= '0;
            ctl_out_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            pre_in_reg   <= pre_in_next;
            pre_out_reg  <= pre_out_next;
            err_last_reg <= err_last_next;
            ctl_out_reg  <= ctl_out_next;
        end
        x_reg   <= x_next;
        fb_reg  <= fb_next;
        acc_reg <= acc_next;
        err_reg <= err_next;
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == ST_MUL_A))
        else $error("accepted beat did not start the sequence");

    a_clamp_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLAMP && !out_free) |=>
            (state_reg == ST_CLAMP && $stable(ctl_out_reg)))
        else $error("result committed while output was blocked");

    a_high_windup: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_flag == LIM_HIGH) |=> (ctl_out_reg == $past(UW'(hi_u))))
        else $error("stored output not set to high limit on clamp");

    a_low_windup: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_flag == LIM_LOW) |=> (ctl_out_reg == $past(UW'(lo_u))))
        else $error("stored output not set to low limit on clamp");

endmodule

@@ rtl/pi_controller_prefilter_clamp_top.sv @@
// PI controller with first-order reference prefilter and clamp anti-windup.
//
// Input stream (s_*): one beat per control tick carries the setpoint and the
// measured feedback sample. Output stream (m_*): one beat per input beat with
// the clamped drive value and a limit flag (0 in range, 1 high, 2 low).
// Configuration channel (cfg_*): writes coefficient and limit registers by
// index; cfg_ready is always high. Write only while no tick is in flight.
//
// All five products of a tick go one after another through a single shared
// multiplier with a registered output, and s_tready is high only while the
// sequencer is idle, so a new tick is taken only once the last one is done.
//
// A finished result sits in the output register; the next tick runs while it
// waits, and the sequencer holds at its last step until the register is free.
// Reset clears the filter and controller history to zero and loads unity
// gains, zero for the other coefficients, and the full output range.
module pi_controller_prefilter_clamp_top
    import pcf_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,   // setpoint, measured
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,    // drive
    output logic [1:0]                        m_tuser,    // limited
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]         cfg_index,
    input  logic [CFG_DATA_BITS-1:0]          cfg_data
);

    localparam int OUT_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    pcf_coefs_t                    coefs;
    logic                          out_free;
    logic                          res_valid;
    logic [SAMPLE_BITS-1:0]        res_drive;
    limit_flag_t                   res_flag;
    logic signed [SAMPLE_BITS-1:0] setpoint;
    logic signed [SAMPLE_BITS-1:0] measured;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_BITS-1:0] drive_reg, drive_next;
    limit_flag_t            flag_reg, flag_next;

    assign setpoint = s_tdata[SAMPLE_BITS-1:0];
    assign measured = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    pcf_cfg #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    pcf_core #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coefs     (coefs),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .setpoint  (setpoint),
        .measured  (measured),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_drive (res_drive),
        .res_flag  (res_flag)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        drive_next    = drive_reg;
        flag_next     = flag_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            drive_next    = res_drive;
            flag_next     = res_flag;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        drive_reg <= drive_next;
        flag_reg  <= flag_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_BITS'(drive_reg);
    assign m_tuser  = flag_reg;

endmodule
